@@ src/cafs_pkg.sv @@
// ----------------------------------------------------------------------------
// cafs_pkg
// Shared types and constants for the contrast autofocus sequencer.
// ----------------------------------------------------------------------------
package cafs_pkg;

	localparam int unsigned SHARP_W  = 24;
	localparam int unsigned HEIGHT_W = 12;
	localparam int unsigned POS_W    = 8;
	localparam int unsigned STEP_W   = 7;
	localparam int unsigned FCNT_W   = 4;
	localparam int unsigned ERR_W    = 16;
	localparam int unsigned FSTEP_W  = 6;
	localparam int unsigned DROP_W   = 16;

	localparam logic [1:0] REG_FOCUS_STEP     = 2'd0;
	localparam logic [1:0] REG_SHARPNESS_DROP = 2'd1;
	localparam logic [1:0] REG_FAR_END        = 2'd2;

	localparam logic [0:0] CMD_FRAME    = 1'b0;
	localparam logic [0:0] CMD_RETARGET = 1'b1;

	localparam logic [FCNT_W-1:0]   TRACK_WINDOW = 4'd10;
	localparam logic [ERR_W-1:0]    STABLE_LIMIT = 16'd5;
	localparam logic [HEIGHT_W-1:0] SIZE_LIMIT   = 12'd5;

	localparam logic [FSTEP_W-1:0] FOCUS_STEP_RST     = 6'd5;
	localparam logic [DROP_W-1:0]  SHARPNESS_DROP_RST = 16'd1024;
	localparam logic [POS_W-1:0]   FAR_END_RST        = 8'd200;

	typedef struct packed {
		logic                       sweep_mode;
		logic [POS_W-1:0]           focus_pos;
		logic [POS_W-1:0]           best_pos;
		logic [SHARP_W-1:0]         best_sharp;
		logic [SHARP_W-1:0]         last_sharp;
		logic [FCNT_W-1:0]          frame_count;
		logic [ERR_W-1:0]           error_sum;
		logic [HEIGHT_W-1:0]        ref_height;
		logic [HEIGHT_W-1:0]        prev_height;
		logic signed [STEP_W-1:0]   step_signed;
		logic [POS_W-1:0]           sweep_end;
	} cafs_state_t;

endpackage

@@ src/contrast_autofocus_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// contrast_autofocus_sequencer_unit
// Per-frame lens focus sequencer: contrast sweep, then size-change tracking.
// ----------------------------------------------------------------------------
// One beat per clock in while in_stall is low, one result beat per input beat
// out. An input beat is captured in an input register; the whole sequencer
// state is then updated in one pass and the result lands in the output
// register; sustained throughput is 1 beat per cycle while out_stall is low.
// The output register stalls the input side only while a result is held and
// out_stall is high. Registers are at byte addresses 0 (focus_step),
// 4 (sharpness_drop), 8 (far_end).
module contrast_autofocus_sequencer_unit (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [3:0]                      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,

	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            cmd,
	input  logic [cafs_pkg::SHARP_W-1:0]    sharpness,
	input  logic [cafs_pkg::HEIGHT_W-1:0]   object_height,

	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [cafs_pkg::POS_W-1:0]      focus_position,
	output logic                            focus_write,
	output logic                            sweeping,
	output logic [cafs_pkg::POS_W-1:0]      best_focus
);

	logic [cafs_pkg::FSTEP_W-1:0] focus_step_q;
	logic [cafs_pkg::DROP_W-1:0]  sharpness_drop_q;
	logic [cafs_pkg::POS_W-1:0]   far_end_q;

	logic                            valid_s1;
	logic                            cmd_s1;
	logic [cafs_pkg::SHARP_W-1:0]    sharpness_s1;
	logic [cafs_pkg::HEIGHT_W-1:0]   object_height_s1;
	logic                            adv_s1;

	cafs_pkg::cafs_state_t st_q;
	cafs_pkg::cafs_state_t st_d;
	logic                  write_d;

	logic                            out_valid_q;
	logic [cafs_pkg::POS_W-1:0]      focus_position_q;
	logic                            focus_write_q;
	logic                            sweeping_q;
	logic [cafs_pkg::POS_W-1:0]      best_focus_q;

	logic cfg_wr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focus_step_q     <= cafs_pkg::FOCUS_STEP_RST;
			sharpness_drop_q <= cafs_pkg::SHARPNESS_DROP_RST;
			far_end_q        <= cafs_pkg::FAR_END_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				cafs_pkg::REG_FOCUS_STEP:     focus_step_q     <= pwdata[cafs_pkg::FSTEP_W-1:0];
				cafs_pkg::REG_SHARPNESS_DROP: sharpness_drop_q <= pwdata[cafs_pkg::DROP_W-1:0];
				cafs_pkg::REG_FAR_END:        far_end_q        <= pwdata[cafs_pkg::POS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			cafs_pkg::REG_FOCUS_STEP:     prdata = {26'd0, focus_step_q};
			cafs_pkg::REG_SHARPNESS_DROP: prdata = {16'd0, sharpness_drop_q};
			cafs_pkg::REG_FAR_END:        prdata = {24'd0, far_end_q};
			default:                      prdata = 32'd0;
		endcase
	end

	// input register
	assign adv_s1   = ~out_valid_q | ~out_stall;
	assign in_stall = valid_s1 & ~adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_s1           <= cmd;
			sharpness_s1     <= sharpness;
			object_height_s1 <= object_height;
		end
	end

	// state update
	always_comb begin
		logic [cafs_pkg::FCNT_W-1:0]   fc1;
		logic signed [9:0]             fsum;
		logic [cafs_pkg::POS_W-1:0]    fclamp;
		logic                          reached;
		logic [cafs_pkg::SHARP_W:0]    drop_sum;
		logic [cafs_pkg::HEIGHT_W-1:0] hdiff;
		logic [cafs_pkg::ERR_W:0]      esum;
		logic [cafs_pkg::ERR_W-1:0]    err_new;
		logic [cafs_pkg::HEIGHT_W-1:0] sdiff;
		logic                          grew;

		st_d    = st_q;
		write_d = 1'b0;

		fc1    = st_q.frame_count + 4'd1;
		fsum   = $signed({2'b00, st_q.focus_pos}) +
		         $signed({{3{st_q.step_signed[cafs_pkg::STEP_W-1]}}, st_q.step_signed});
		fclamp = (fsum < 10'sd0) ? 8'd0 : ((fsum > 10'sd255) ? 8'd255 : fsum[7:0]);
		reached  = 1'b0;
		drop_sum = {1'b0, sharpness_s1} + {9'd0, sharpness_drop_q};
		hdiff  = (object_height_s1 > st_q.prev_height) ? object_height_s1 - st_q.prev_height
		                                               : st_q.prev_height - object_height_s1;
		esum   = {1'b0, st_q.error_sum} + {5'd0, hdiff};
		err_new = esum[cafs_pkg::ERR_W] ? {cafs_pkg::ERR_W{1'b1}} : esum[cafs_pkg::ERR_W-1:0];
		grew   = object_height_s1 > st_q.ref_height;
		sdiff  = grew ? object_height_s1 - st_q.ref_height : st_q.ref_height - object_height_s1;

		if (cmd_s1 == cafs_pkg::CMD_RETARGET) begin
			st_d.focus_pos   = '0;
			st_d.best_pos    = '0;
			st_d.best_sharp  = '0;
			st_d.last_sharp  = '0;
			st_d.ref_height  = object_height_s1;
			st_d.step_signed = $signed({1'b0, focus_step_q});
			st_d.sweep_end   = far_end_q;
			st_d.sweep_mode  = 1'b1;
		end else if (st_q.sweep_mode) begin
			write_d = 1'b1;
			if (sharpness_s1 > st_q.last_sharp) begin
				if (sharpness_s1 > st_q.best_sharp) begin
					st_d.best_sharp = sharpness_s1;
					st_d.best_pos   = st_q.focus_pos;
				end
				st_d.last_sharp = sharpness_s1;
			end
			st_d.frame_count = fc1;
			// move the lens every third frame
			if (fc1 == 4'd0 || fc1 == 4'd3 || fc1 == 4'd6 || fc1 == 4'd9 ||
			    fc1 == 4'd12 || fc1 == 4'd15) begin
				st_d.focus_pos   = fclamp;
				st_d.frame_count = '0;
			end
			if (st_q.step_signed[cafs_pkg::STEP_W-1])
				reached = st_d.focus_pos <= st_q.sweep_end;
			else
				reached = st_d.focus_pos >= st_q.sweep_end;
			if (reached || drop_sum < {1'b0, st_d.best_sharp}) begin
				st_d.sweep_mode  = 1'b0;
				st_d.focus_pos   = st_d.best_pos;
				st_d.ref_height  = object_height_s1;
				st_d.prev_height = object_height_s1;
			end
		end else begin
			st_d.frame_count = fc1;
			st_d.error_sum   = err_new;
			st_d.prev_height = object_height_s1;
			if (fc1 >= cafs_pkg::TRACK_WINDOW) begin
				if (err_new < cafs_pkg::STABLE_LIMIT && sdiff > cafs_pkg::SIZE_LIMIT) begin
					st_d.sweep_mode = 1'b1;
					st_d.best_sharp = '0;
					st_d.last_sharp = '0;
					if (grew) begin
						st_d.step_signed = $signed({1'b0, focus_step_q});
						st_d.sweep_end   = far_end_q;
					end else begin
						st_d.step_signed = -$signed({1'b0, focus_step_q});
						st_d.sweep_end   = '0;
					end
				end
				st_d.error_sum   = '0;
				st_d.frame_count = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.sweep_mode  <= 1'b1;
			st_q.focus_pos   <= '0;
			st_q.best_pos    <= '0;
			st_q.best_sharp  <= '0;
			st_q.last_sharp  <= '0;
			st_q.frame_count <= '0;
			st_q.error_sum   <= '0;
			st_q.ref_height  <= '0;
			st_q.prev_height <= '0;
			st_q.step_signed <= $signed({1'b0, cafs_pkg::FOCUS_STEP_RST});
			st_q.sweep_end   <= cafs_pkg::FAR_END_RST;
		end else if (valid_s1 && adv_s1) begin
			st_q <= st_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) begin
			focus_position_q <= st_d.focus_pos;
			focus_write_q    <= write_d;
			sweeping_q       <= st_d.sweep_mode;
			best_focus_q     <= st_d.best_pos;
		end
	end

	assign out_valid      = out_valid_q;
	assign focus_position = focus_position_q;
	assign focus_write    = focus_write_q;
	assign sweeping       = sweeping_q;
	assign best_focus     = best_focus_q;

	// checks
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(sharpness_s1) && $stable(cmd_s1))
		else $error("input register changed while blocked");

	a_state_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && adv_s1) |=> $stable(st_q))
		else $error("state changed without a beat");

	a_dir_end: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.step_signed[cafs_pkg::STEP_W-1] |-> st_q.sweep_end == '0)
		else $error("inward sweep with nonzero end");

	a_best_ge_last: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.best_sharp >= st_q.last_sharp)
		else $error("best sharpness below last sharpness");

endmodule
